FILE: design/float_pow_square_multiply_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the square-and-multiply power block
// Shared property forms used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FLOAT_POW_SQUARE_MULTIPLY_TOP_ASSERT_SVH
`define FLOAT_POW_SQUARE_MULTIPLY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define FPW_ASSERT_SAME(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the trigger.
`define FPW_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/fpw_pkg.sv
// ---------------------------------------------------------------------------
// fpw_pkg
// Shared types and constants for the square-and-multiply power block.
// ---------------------------------------------------------------------------
package fpw_pkg;

  // Default exponent width.
  localparam int EXPONENT_BITS_DEF = 32;

  // Binary64 constants.
  localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] MONE_BITS   = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  // Controller states.
  typedef enum logic [3:0] {
    C_IDLE, C_CHECK, C_STEP, C_MUL, C_MUL_WAIT, C_SQ, C_SQ_WAIT,
    C_LOOP_END, C_RECIP, C_RECIP_WAIT, C_FINISH
  } ctrl_state_t;

  // Arithmetic unit states.
  typedef enum logic [2:0] {
    FPU_IDLE, FPU_MUL, FPU_DNORM, FPU_DIV, FPU_NORM, FPU_ROUND, FPU_DONE
  } fpu_state_t;

  // Source of an accumulator write.
  typedef enum logic {ACC_FPU, ACC_INF} acc_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     fpu_start;
    logic     fpu_div;
    logic     op_square;
    logic     wr_acc;
    acc_src_t acc_src;
    logic     wr_sq;
    logic     shift_mag;
    logic     write_out;
  } fpw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic base_one;
    logic base_mone;
    logic mag_zero;
    logic mag_bit0;
    logic mag_last;
    logic negative;
    logic acc_zero;
    logic fpu_busy;
    logic fpu_done;
  } fpw_status_t;

endpackage

FILE: design/float_pow_square_multiply_top.sv
// ---------------------------------------------------------------------------
// float_pow_square_multiply_top
// Binary64 base raised to a signed integer power by square-and-multiply.
// ---------------------------------------------------------------------------
// Usage: the slave channel takes one transaction holding the base (binary64)
// and the signed exponent; the master channel returns one binary64 result
// per input, rounded to nearest even. Items are processed one at a time.
// Sequence: a check state after acceptance, then for each exponent bit a
// decision state, on a set bit a multiply and, but for the last bit, a squaring,
// all on the shared arithmetic unit. A negative exponent adds a reciprocal
// (a zero power turns into the infinity of its sign instead). Bases of one and
// minus one and a zero exponent go from the check straight to the output.
// Reset clears the controller and the output valid; no result is pending.
// When the receiver stalls, the result waits in the output register; the
// next input is accepted meanwhile and worked on, and its result is held
// back until the output register is free.
// ---------------------------------------------------------------------------
module float_pow_square_multiply_top #(
  parameter int EXPONENT_BITS = fpw_pkg::EXPONENT_BITS_DEF,
  localparam int TDATA_W = ((64 + EXPONENT_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,  // base_bits[63:0], exponent, zero fill
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [63:0]        m_tdata   // result_bits[63:0]
);

  fpw_pkg::fpw_cmd_t    cmd;
  fpw_pkg::fpw_status_t status;

  // Sequencer.
  fpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers and arithmetic.
  fpw_datapath #(
    .EXPONENT_BITS (EXPONENT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_base  (s_tdata[63:0]),
    .in_exp   (s_tdata[64 +: EXPONENT_BITS]),
    .out_data (m_tdata)
  );

  `include "float_pow_square_multiply_top_assert.svh"

  // One item in flight: no new input right after an accepted one.
  `FPW_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // Writing the output register always presents a result.
  `FPW_ASSERT_NEXT(a_out_valid, clk, rst, cmd.write_out, m_tvalid)
  // The arithmetic unit is only started when it is idle.
  `FPW_ASSERT_SAME(a_fpu_idle, clk, rst, cmd.fpu_start, !status.fpu_busy)

endmodule

FILE: design/fpw_fpu.sv
// ---------------------------------------------------------------------------
// fpw_fpu
// Multi-cycle binary64 multiplier and reciprocal unit, round to nearest even.
// ---------------------------------------------------------------------------
module fpw_fpu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        div,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);

  fpw_pkg::fpu_state_t state, state_next;

  logic [105:0]       prod;
  logic               stk;
  logic signed [12:0] e;
  logic               sgn;
  logic [52:0]        ma, mb;
  logic [53:0]        pp;
  logic [5:0]         cnt;
  logic [53:0]        rem;
  logic [57:0]        q;

  // Operand classification.
  logic [10:0] ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        special;
  logic [63:0] special_val;
  logic        psign;

  assign ea     = a[62:52];
  assign eb     = b[62:52];
  assign a_nan  = (&ea) && (|a[51:0]);
  assign b_nan  = (&eb) && (|b[51:0]);
  assign a_inf  = (&ea) && !(|a[51:0]);
  assign b_inf  = (&eb) && !(|b[51:0]);
  assign a_zero = (a[62:0] == 63'd0);
  assign b_zero = (b[62:0] == 63'd0);
  assign psign  = a[63] ^ b[63];

  always_comb begin
    special     = 1'b1;
    special_val = 64'd0;
    if (div) begin
      if (a_nan) begin
        special_val = a | fpw_pkg::QUIET_BIT;
      end else if (a_inf) begin
        special_val = {a[63], 63'd0};
      end else if (a_zero) begin
        special_val = {a[63], fpw_pkg::INF_BITS[62:0]};
      end else begin
        special = 1'b0;
      end
    end else begin
      if (a_nan) begin
        special_val = a | fpw_pkg::QUIET_BIT;
      end else if (b_nan) begin
        special_val = b | fpw_pkg::QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
        special_val = fpw_pkg::DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
        special_val = {psign, fpw_pkg::INF_BITS[62:0]};
      end else if (a_zero || b_zero) begin
        special_val = {psign, 63'd0};
      end else begin
        special = 1'b0;
      end
    end
  end

  // Partial product operand selection, 27-bit halves.
  logic [26:0] opa, opb;
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin opa = ma[26:0];          opb = mb[26:0];          end
      2'd1:    begin opa = ma[26:0];          opb = {1'b0, mb[52:27]}; end
      2'd2:    begin opa = {1'b0, ma[52:27]}; opb = mb[26:0];          end
      default: begin opa = {1'b0, ma[52:27]}; opb = {1'b0, mb[52:27]}; end
    endcase
  end

  // Shifted partial product for accumulation.
  logic [105:0] pp_sh;
  always_comb begin
    case (cnt)
      6'd1:        pp_sh = {52'd0, pp};
      6'd2, 6'd3:  pp_sh = {25'd0, pp, 27'd0};
      6'd4:        pp_sh = {pp[51:0], 54'd0};
      default:     pp_sh = 106'd0;
    endcase
  end

  // Restoring division step.
  logic        ge;
  logic [53:0] rem_sub, rem_n;
  logic [57:0] q_n;
  assign ge      = (rem >= {1'b0, mb});
  assign rem_sub = ge ? (rem - {1'b0, mb}) : rem;
  assign rem_n   = {rem_sub[52:0], 1'b0};
  assign q_n     = {q[56:0], ge};

  // Rounding.
  logic [52:0]        kept;
  logic               guard, sticky, inc;
  logic [53:0]        rsum;
  logic signed [12:0] eo;
  logic [51:0]        frac;
  logic [63:0]        rounded;
  assign kept   = prod[105:53];
  assign guard  = prod[52];
  assign sticky = (|prod[51:0]) | stk;
  assign inc    = guard & (sticky | kept[0]);
  assign rsum   = {1'b0, kept} + {53'd0, inc};

  always_comb begin
    if (rsum[53]) begin
      eo   = e + 13'sd1;
      frac = 52'd0;
    end else begin
      eo   = rsum[52] ? e : 13'sd0;
      frac = rsum[51:0];
    end
    if (eo >= 13'sd2047) begin
      rounded = {sgn, fpw_pkg::INF_BITS[62:0]};
    end else begin
      rounded = {sgn, eo[10:0], frac};
    end
  end

  // Biased exponents with subnormals read as exponent one.
  logic signed [12:0] ea_s, eb_s;
  assign ea_s = (ea == 11'd0) ? 13'sd1 : $signed({2'b00, ea});
  assign eb_s = (eb == 11'd0) ? 13'sd1 : $signed({2'b00, eb});

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpw_pkg::FPU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fpw_pkg::FPU_IDLE: begin
        if (start) begin
          if (special) state_next = fpw_pkg::FPU_DONE;
          else if (div) state_next = fpw_pkg::FPU_DNORM;
          else state_next = fpw_pkg::FPU_MUL;
        end
      end
      fpw_pkg::FPU_MUL:   if (cnt == 6'd4) state_next = fpw_pkg::FPU_NORM;
      fpw_pkg::FPU_DNORM: if (mb[52]) state_next = fpw_pkg::FPU_DIV;
      fpw_pkg::FPU_DIV:   if (cnt == 6'd57) state_next = fpw_pkg::FPU_NORM;
      fpw_pkg::FPU_NORM: begin
        if (!(e < 13'sd1) && !(!prod[105] && e > 13'sd1)) state_next = fpw_pkg::FPU_ROUND;
      end
      fpw_pkg::FPU_ROUND: state_next = fpw_pkg::FPU_DONE;
      fpw_pkg::FPU_DONE:  state_next = fpw_pkg::FPU_IDLE;
      default:            state_next = fpw_pkg::FPU_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      fpw_pkg::FPU_IDLE: begin
        if (start) begin
          result <= special_val;
          cnt    <= 6'd0;
          prod   <= 106'd0;
          stk    <= 1'b0;
          if (div) begin
            sgn <= a[63];
            mb  <= {(ea != 11'd0), a[51:0]};
            e   <= ea_s;
          end else begin
            sgn <= psign;
            ma  <= {(ea != 11'd0), a[51:0]};
            mb  <= {(eb != 11'd0), b[51:0]};
            e   <= ea_s + eb_s - 13'sd1022;
          end
        end
      end
      fpw_pkg::FPU_MUL: begin
        pp   <= {27'd0, opa} * {27'd0, opb};
        prod <= prod + pp_sh;
        cnt  <= cnt + 6'd1;
      end
      fpw_pkg::FPU_DNORM: begin
        if (mb[52]) begin
          rem <= {2'b01, 52'd0};
          cnt <= 6'd0;
        end else if (mb[52:45] == 8'd0) begin
          mb <= {mb[44:0], 8'd0};
          e  <= e - 13'sd8;
        end else begin
          mb <= {mb[51:0], 1'b0};
          e  <= e - 13'sd1;
        end
      end
      fpw_pkg::FPU_DIV: begin
        rem <= rem_n;
        q   <= q_n;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd57) begin
          prod <= {q_n, 48'd0};
          stk  <= |rem_n;
          e    <= 13'sd2046 - e;
        end
      end
      fpw_pkg::FPU_NORM: begin
        if (e < -13'sd120) begin
          stk  <= stk | (|prod);
          prod <= 106'd0;
          e    <= 13'sd1;
        end else if (e <= -13'sd7) begin
          stk  <= stk | (|prod[7:0]);
          prod <= {8'd0, prod[105:8]};
          e    <= e + 13'sd8;
        end else if (e < 13'sd1) begin
          stk  <= stk | prod[0];
          prod <= {1'b0, prod[105:1]};
          e    <= e + 13'sd1;
        end else if (!prod[105] && e > 13'sd1) begin
          if (prod[105:98] == 8'd0 && e > 13'sd8) begin
            prod <= {prod[97:0], 8'd0};
            e    <= e - 13'sd8;
          end else begin
            prod <= {prod[104:0], 1'b0};
            e    <= e - 13'sd1;
          end
        end
      end
      fpw_pkg::FPU_ROUND: result <= rounded;
      default: ;
    endcase
  end

  assign busy = (state != fpw_pkg::FPU_IDLE);
  assign done = (state == fpw_pkg::FPU_DONE);

endmodule

FILE: design/fpw_datapath.sv
// ---------------------------------------------------------------------------
// fpw_datapath
// Operand registers, exponent magnitude shifter and the shared arithmetic unit.
// ---------------------------------------------------------------------------
module fpw_datapath #(
  parameter int EXPONENT_BITS = fpw_pkg::EXPONENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fpw_pkg::fpw_cmd_t        cmd,
  output fpw_pkg::fpw_status_t     status,
  input  logic [63:0]              in_base,
  input  logic [EXPONENT_BITS-1:0] in_exp,
  output logic [63:0]              out_data
);

  logic [63:0]              base;
  logic [63:0]              acc;
  logic [63:0]              sq;
  logic [EXPONENT_BITS-1:0] mag;
  logic                     negative;
  logic                     odd;
  logic                     fpu_busy, fpu_done;
  logic [63:0]              fpu_result;
  logic                     base_one, base_mone;

  // Shared multiply and reciprocal unit.
  fpw_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.fpu_start),
    .div    (cmd.fpu_div),
    .a      (cmd.op_square ? sq : acc),
    .b      (sq),
    .busy   (fpu_busy),
    .done   (fpu_done),
    .result (fpu_result)
  );

  assign base_one  = (base == fpw_pkg::ONE_BITS);
  assign base_mone = (base == fpw_pkg::MONE_BITS);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base     <= in_base;
      sq       <= in_base;
      acc      <= fpw_pkg::ONE_BITS;
      negative <= in_exp[EXPONENT_BITS-1];
      odd      <= in_exp[0];
      mag      <= in_exp[EXPONENT_BITS-1] ? ({EXPONENT_BITS{1'b0}} - in_exp) : in_exp;
    end else begin
      if (cmd.wr_acc) begin
        acc <= (cmd.acc_src == fpw_pkg::ACC_INF) ?
               {acc[63], fpw_pkg::INF_BITS[62:0]} : fpu_result;
      end
      if (cmd.wr_sq) sq <= fpu_result;
      if (cmd.shift_mag) mag <= {1'b0, mag[EXPONENT_BITS-1:1]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      if (base_one) out_data <= fpw_pkg::ONE_BITS;
      else if (base_mone) out_data <= odd ? fpw_pkg::MONE_BITS : fpw_pkg::ONE_BITS;
      else out_data <= acc;
    end
  end

  assign status.base_one  = base_one;
  assign status.base_mone = base_mone;
  assign status.mag_zero  = (mag == {EXPONENT_BITS{1'b0}});
  assign status.mag_bit0  = mag[0];
  assign status.mag_last  = (mag[EXPONENT_BITS-1:1] == {(EXPONENT_BITS-1){1'b0}});
  assign status.negative  = negative;
  assign status.acc_zero  = (acc[62:0] == 63'd0);
  assign status.fpu_busy  = fpu_busy;
  assign status.fpu_done  = fpu_done;

endmodule

FILE: design/fpw_ctrl.sv
// ---------------------------------------------------------------------------
// fpw_ctrl
// Sequencer for the square-and-multiply loop and the final reciprocal.
// ---------------------------------------------------------------------------
module fpw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  fpw_pkg::fpw_status_t status,
  output fpw_pkg::fpw_cmd_t    cmd
);

  fpw_pkg::ctrl_state_t state, state_next;
  logic                 m_tvalid_next;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fpw_pkg::C_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.acc_src = fpw_pkg::ACC_FPU;
    s_tready    = 1'b0;
    unique case (state)
      fpw_pkg::C_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = fpw_pkg::C_CHECK;
        end
      end
      fpw_pkg::C_CHECK: begin
        if (status.base_one || status.base_mone || status.mag_zero) begin
          state_next = fpw_pkg::C_FINISH;
        end else begin
          state_next = fpw_pkg::C_STEP;
        end
      end
      fpw_pkg::C_STEP: state_next = status.mag_bit0 ? fpw_pkg::C_MUL : fpw_pkg::C_SQ;
      fpw_pkg::C_MUL: begin
        cmd.fpu_start = 1'b1;
        state_next    = fpw_pkg::C_MUL_WAIT;
      end
      fpw_pkg::C_MUL_WAIT: begin
        if (status.fpu_done) begin
          cmd.wr_acc = 1'b1;
          state_next = status.mag_last ? fpw_pkg::C_LOOP_END : fpw_pkg::C_SQ;
        end
      end
      fpw_pkg::C_SQ: begin
        cmd.fpu_start = 1'b1;
        cmd.op_square = 1'b1;
        state_next    = fpw_pkg::C_SQ_WAIT;
      end
      fpw_pkg::C_SQ_WAIT: begin
        if (status.fpu_done) begin
          cmd.wr_sq     = 1'b1;
          cmd.shift_mag = 1'b1;
          state_next    = fpw_pkg::C_STEP;
        end
      end
      fpw_pkg::C_LOOP_END: begin
        if (!status.negative) begin
          state_next = fpw_pkg::C_FINISH;
        end else if (status.acc_zero) begin
          // Reciprocal of a signed zero is the infinity of that sign.
          cmd.wr_acc  = 1'b1;
          cmd.acc_src = fpw_pkg::ACC_INF;
          state_next  = fpw_pkg::C_FINISH;
        end else begin
          state_next = fpw_pkg::C_RECIP;
        end
      end
      fpw_pkg::C_RECIP: begin
        cmd.fpu_start = 1'b1;
        cmd.fpu_div   = 1'b1;
        state_next    = fpw_pkg::C_RECIP_WAIT;
      end
      fpw_pkg::C_RECIP_WAIT: begin
        if (status.fpu_done) begin
          cmd.wr_acc = 1'b1;
          state_next = fpw_pkg::C_FINISH;
        end
      end
      fpw_pkg::C_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.write_out = 1'b1;
          state_next    = fpw_pkg::C_IDLE;
        end
      end
      default: state_next = fpw_pkg::C_IDLE;
    endcase
  end

  // Output register holds its transaction until taken.
  always_comb begin
    if (cmd.write_out) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

endmodule
